[design/urrb_pkg.sv]
package urrb_pkg;

    localparam int BUFFER_DEPTH = 256;
    localparam int IDX_W = $clog2(BUFFER_DEPTH);
    localparam logic [IDX_W:0] DEPTH_W = (IDX_W + 1)'(BUFFER_DEPTH);
    localparam logic [7:0] WATERMARK_RESET = 8'd128;

    localparam int ERR_FRAME_BIT = 0;
    localparam int ERR_OVERRUN_BIT = 1;
    localparam int ERR_OVERFLOW_BIT = 2;

    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic [1:0] {
        KIND_BYTE      = 2'd0,
        KIND_READ      = 2'd1,
        KIND_NEAR_FLAG = 2'd2,
        KIND_OVF_FLAG  = 2'd3
    } kind_t;

    typedef struct packed {
        logic       rd_ok;
        logic       no_data;
        logic       frame_error_seen;
        logic       overrun_seen;
        logic       buffer_overflow_seen;
        logic [7:0] fill_count;
        logic       near_empty_flag;
        logic       overflow_flag;
    } result_t;

    typedef idx_t wm_table_t [256];

    function automatic idx_t ring_next(input idx_t i);
        logic [IDX_W:0] n;
        n = {1'b0, i} + 1'b1;
        return (n >= DEPTH_W) ? '0 : n[IDX_W-1:0];
    endfunction

    function automatic wm_table_t build_wm_table();
        wm_table_t t;
        for (int v = 0; v < 256; v++)
        begin
            t[v] = IDX_W'(v % BUFFER_DEPTH);
        end
        return t;
    endfunction

    localparam wm_table_t WM_MOD = build_wm_table();

endpackage

[design/urrb_if.sv]
interface urrb_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] rx_byte;
    logic       frame_error_in;
    logic       overrun_error_in;
    logic       flag_value;

    modport source (output valid, kind, rx_byte, frame_error_in, overrun_error_in, flag_value,
                    input ready);
    modport sink (input valid, kind, rx_byte, frame_error_in, overrun_error_in, flag_value,
                  output ready);
endinterface

interface urrb_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;
    logic       no_data;
    logic       frame_error_seen;
    logic       overrun_seen;
    logic       buffer_overflow_seen;
    logic [7:0] fill_count;
    logic       near_empty_flag;
    logic       overflow_flag;

    modport source (output valid, read_byte, no_data, frame_error_seen, overrun_seen,
                    buffer_overflow_seen, fill_count, near_empty_flag, overflow_flag,
                    input ready);
    modport sink (input valid, read_byte, no_data, frame_error_seen, overrun_seen,
                  buffer_overflow_seen, fill_count, near_empty_flag, overflow_flag,
                  output ready);
endinterface

[design/uart_receive_ring_buffer.sv]
// Receive byte FIFO behind a serial port. Each request on the item channel is one of four kinds
// (arrived byte, software read, near-empty flag write, overflow flag write) and yields exactly one
// registered result in the cycle after it is taken; a request is taken every cycle while the
// result register is free or being drained. The byte store has one registered read port. The
// ring has urrb_pkg::BUFFER_DEPTH slots and keeps one unused. The store has no reset and needs no
// clearing pass: a read only reaches slots written by an earlier arrival.
module uart_receive_ring_buffer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [7:0]           cfg_wdata,
    urrb_item_if.sink            item,
    urrb_result_if.source        result
);

    logic [7:0]       store [urrb_pkg::BUFFER_DEPTH];
    logic [7:0]       rdata_reg;

    urrb_pkg::idx_t   wi_reg, wi_next;
    urrb_pkg::idx_t   ri_reg, ri_next;
    logic [2:0]       err_reg, err_next;
    logic             near_reg, near_next;
    logic             drop_reg, drop_next;
    logic [7:0]       wm_reg;
    logic             out_valid_reg;
    urrb_pkg::result_t res_reg, res_next;

    logic             accept;
    logic             wr_en;
    logic             rd_en;
    urrb_pkg::idx_t   nh;
    urrb_pkg::idx_t   ri1;
    urrb_pkg::idx_t   wd;
    urrb_pkg::idx_t   probe;
    logic [urrb_pkg::IDX_W:0] probe_sum;
    logic [urrb_pkg::IDX_W:0] fill_diff;
    logic [urrb_pkg::IDX_W:0] fill;

    assign item.ready = !out_valid_reg || result.ready;
    assign accept = item.valid && item.ready;

    assign nh = urrb_pkg::ring_next(wi_reg);
    assign ri1 = urrb_pkg::ring_next(ri_reg);
    assign wd = urrb_pkg::WM_MOD[wm_reg];
    assign probe_sum = {1'b0, nh} + {1'b0, wd};
    assign probe = (probe_sum >= urrb_pkg::DEPTH_W)
                 ? urrb_pkg::idx_t'(probe_sum - urrb_pkg::DEPTH_W)
                 : probe_sum[urrb_pkg::IDX_W-1:0];

    always_comb
    begin
        wi_next = wi_reg;
        ri_next = ri_reg;
        err_next = err_reg;
        near_next = near_reg;
        drop_next = drop_reg;
        wr_en = 1'b0;
        rd_en = 1'b0;
        res_next = '0;
        case (urrb_pkg::kind_t'(item.kind))
            urrb_pkg::KIND_BYTE:
            begin
                if (probe == ri_reg)
                begin
                    near_next = 1'b0;
                end
                if (nh == ri_reg)
                begin
                    err_next = '0;
                    err_next[urrb_pkg::ERR_OVERFLOW_BIT] = 1'b1;
                    drop_next = 1'b1;
                end
                else
                begin
                    wi_next = nh;
                    wr_en = accept;
                    err_next = '0;
                    err_next[urrb_pkg::ERR_FRAME_BIT] = item.frame_error_in;
                    err_next[urrb_pkg::ERR_OVERRUN_BIT] = item.overrun_error_in;
                end
            end
            urrb_pkg::KIND_READ:
            begin
                if (wi_reg == ri_reg)
                begin
                    res_next.no_data = 1'b1;
                end
                else
                begin
                    ri_next = ri1;
                    rd_en = accept;
                    if (urrb_pkg::ring_next(ri1) == wi_reg)
                    begin
                        near_next = 1'b1;
                    end
                    res_next.rd_ok = 1'b1;
                    res_next.frame_error_seen = err_reg[urrb_pkg::ERR_FRAME_BIT];
                    res_next.overrun_seen = err_reg[urrb_pkg::ERR_OVERRUN_BIT];
                    res_next.buffer_overflow_seen = err_reg[urrb_pkg::ERR_OVERFLOW_BIT];
                end
            end
            urrb_pkg::KIND_NEAR_FLAG:
            begin
                near_next = item.flag_value;
            end
            urrb_pkg::KIND_OVF_FLAG:
            begin
                drop_next = item.flag_value;
            end
            default:
            begin
                drop_next = drop_reg;
            end
        endcase
        fill_diff = {1'b0, wi_next} - {1'b0, ri_next};
        fill = (wi_next >= ri_next) ? fill_diff : fill_diff + urrb_pkg::DEPTH_W;
        res_next.fill_count = 8'(fill);
        res_next.near_empty_flag = near_next;
        res_next.overflow_flag = drop_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wi_reg <= '0;
            ri_reg <= '0;
            err_reg <= '0;
            near_reg <= 1'b1;
            drop_reg <= 1'b0;
            wm_reg <= urrb_pkg::WATERMARK_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                wm_reg <= cfg_wdata;
            end
            if (accept)
            begin
                wi_reg <= wi_next;
                ri_reg <= ri_next;
                err_reg <= err_next;
                near_reg <= near_next;
                drop_reg <= drop_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store[nh] <= item.rx_byte;
        end
        if (rd_en)
        begin
            rdata_reg <= store[ri1];
        end
    end

    assign result.valid = out_valid_reg;
    assign result.read_byte = res_reg.rd_ok ? rdata_reg : 8'd0;
    assign result.no_data = res_reg.no_data;
    assign result.frame_error_seen = res_reg.frame_error_seen;
    assign result.overrun_seen = res_reg.overrun_seen;
    assign result.buffer_overflow_seen = res_reg.buffer_overflow_seen;
    assign result.fill_count = res_reg.fill_count;
    assign result.near_empty_flag = res_reg.near_empty_flag;
    assign result.overflow_flag = res_reg.overflow_flag;

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, wi_reg} < urrb_pkg::DEPTH_W) && ({1'b0, ri_reg} < urrb_pkg::DEPTH_W))
        else $error("ring index out of range");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (item.kind == urrb_pkg::KIND_BYTE) && (nh == ri_reg)
        |=> $stable(wi_reg) && $stable(ri_reg) && drop_reg)
        else $error("arrival on full ring moved an index");

    a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (item.kind == urrb_pkg::KIND_READ) && (wi_reg == ri_reg)
        |=> $stable(ri_reg) && res_reg.no_data && !res_reg.rd_ok)
        else $error("read of empty ring moved the read index");

    a_no_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.no_data
        |-> (result.read_byte == 8'd0) && !result.frame_error_seen && !result.overrun_seen
            && !result.buffer_overflow_seen)
        else $error("empty read carried data or errors");
`endif

endmodule

[dv/tb_uart_receive_ring_buffer.sv]
module tb_uart_receive_ring_buffer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       no_data;
        logic       frame_error_seen;
        logic       overrun_seen;
        logic       buffer_overflow_seen;
        logic [7:0] fill_count;
        logic       near_empty_flag;
        logic       overflow_flag;
    } response_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    urrb_item_if   item_ch ();
    urrb_result_if result_ch ();

    uart_receive_ring_buffer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item_ch),
        .result    (result_ch)
    );

    // ring state as the block should hold it
    logic [7:0] ring_mem [urrb_pkg::BUFFER_DEPTH];
    int         wr_pos;
    int         rd_pos;
    logic [2:0] err_latch;
    logic       near_empty_model;
    logic       dropped_model;
    logic [7:0] watermark;

    response_t  pending_responses [$];
    int         error_count = 0;
    int         stall_cycles = 0;
    bit         steady_mode = 1'b0;
    bit         hold_request = 1'b0;

    always #10ns clk = ~clk;

    function automatic int pick_gap();
        int roll;
        if (steady_mode)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    task automatic predict_ring_response(input urrb_pkg::kind_t kind, input logic [7:0] value,
                                         input logic fe, input logic ovr, input logic fv,
                                         output response_t rsp);
        int nxt;
        int probe;
        rsp = '0;
        case (kind)
            urrb_pkg::KIND_BYTE:
            begin
                nxt = (wr_pos + 1) % urrb_pkg::BUFFER_DEPTH;
                probe = (nxt + (int'(watermark) % urrb_pkg::BUFFER_DEPTH))
                        % urrb_pkg::BUFFER_DEPTH;
                if (probe == rd_pos)
                    near_empty_model = 1'b0;
                err_latch = '0;
                if (nxt == rd_pos)
                begin
                    err_latch[urrb_pkg::ERR_OVERFLOW_BIT] = 1'b1;
                    dropped_model = 1'b1;
                end
                else
                begin
                    wr_pos = nxt;
                    ring_mem[nxt] = value;
                    err_latch[urrb_pkg::ERR_FRAME_BIT] = fe;
                    err_latch[urrb_pkg::ERR_OVERRUN_BIT] = ovr;
                end
            end
            urrb_pkg::KIND_READ:
            begin
                if (wr_pos == rd_pos)
                    rsp.no_data = 1'b1;
                else
                begin
                    rd_pos = (rd_pos + 1) % urrb_pkg::BUFFER_DEPTH;
                    if ((rd_pos + 1) % urrb_pkg::BUFFER_DEPTH == wr_pos)
                        near_empty_model = 1'b1;
                    rsp.read_byte = ring_mem[rd_pos];
                    rsp.frame_error_seen = err_latch[urrb_pkg::ERR_FRAME_BIT];
                    rsp.overrun_seen = err_latch[urrb_pkg::ERR_OVERRUN_BIT];
                    rsp.buffer_overflow_seen = err_latch[urrb_pkg::ERR_OVERFLOW_BIT];
                end
            end
            urrb_pkg::KIND_NEAR_FLAG:
                near_empty_model = fv;
            default:
                dropped_model = fv;
        endcase
        rsp.fill_count = 8'((wr_pos - rd_pos + urrb_pkg::BUFFER_DEPTH)
                            % urrb_pkg::BUFFER_DEPTH);
        rsp.near_empty_flag = near_empty_model;
        rsp.overflow_flag = dropped_model;
    endtask

    always @(posedge clk)
    begin : response_check
        response_t got;
        response_t want;
        if (result_ch.valid && result_ch.ready)
        begin
            got.read_byte = result_ch.read_byte;
            got.no_data = result_ch.no_data;
            got.frame_error_seen = result_ch.frame_error_seen;
            got.overrun_seen = result_ch.overrun_seen;
            got.buffer_overflow_seen = result_ch.buffer_overflow_seen;
            got.fill_count = result_ch.fill_count;
            got.near_empty_flag = result_ch.near_empty_flag;
            got.overflow_flag = result_ch.overflow_flag;
            if (pending_responses.size() == 0)
                report_mismatch("response with no request pending", got.fill_count, 0);
            else
            begin
                want = pending_responses.pop_front();
                if (got.read_byte !== want.read_byte)
                    report_mismatch("read_byte", got.read_byte, want.read_byte);
                if (got.no_data !== want.no_data)
                    report_mismatch("no_data", got.no_data, want.no_data);
                if (got.frame_error_seen !== want.frame_error_seen)
                    report_mismatch("frame_error_seen", got.frame_error_seen,
                                    want.frame_error_seen);
                if (got.overrun_seen !== want.overrun_seen)
                    report_mismatch("overrun_seen", got.overrun_seen, want.overrun_seen);
                if (got.buffer_overflow_seen !== want.buffer_overflow_seen)
                    report_mismatch("buffer_overflow_seen", got.buffer_overflow_seen,
                                    want.buffer_overflow_seen);
                if (got.fill_count !== want.fill_count)
                    report_mismatch("fill_count", got.fill_count, want.fill_count);
                if (got.near_empty_flag !== want.near_empty_flag)
                    report_mismatch("near_empty_flag", got.near_empty_flag,
                                    want.near_empty_flag);
                if (got.overflow_flag !== want.overflow_flag)
                    report_mismatch("overflow_flag", got.overflow_flag, want.overflow_flag);
            end
        end
        if (item_ch.valid && item_ch.ready)
        begin
            predict_ring_response(urrb_pkg::kind_t'(item_ch.kind), item_ch.rx_byte,
                                  item_ch.frame_error_in, item_ch.overrun_error_in,
                                  item_ch.flag_value, want);
            pending_responses.push_back(want);
        end
    end

    // no progress on either channel for too long
    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("uart_receive_ring_buffer verification failed");
            $finish;
        end
    end

    initial
    begin : response_receiver
        int idle;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                result_ch.ready <= 1'b1;
            end
            else
            begin
                idle = pick_gap();
                if (idle == 0)
                    result_ch.ready <= 1'b1;
                else
                begin
                    result_ch.ready <= 1'b0;
                    repeat (idle) @(posedge clk);
                    result_ch.ready <= 1'b1;
                end
            end
        end
    end

    task automatic send_request(input urrb_pkg::kind_t kind, input logic [7:0] value,
                                input logic fe, input logic ovr, input logic fv);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.kind <= kind;
        item_ch.rx_byte <= value;
        item_ch.frame_error_in <= fe;
        item_ch.overrun_error_in <= ovr;
        item_ch.flag_value <= fv;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_arrival(input logic [7:0] value, input logic fe, input logic ovr);
        send_request(urrb_pkg::KIND_BYTE, value, fe, ovr, 1'($urandom));
    endtask

    task automatic send_random_arrival();
        send_arrival(8'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic send_read();
        send_request(urrb_pkg::KIND_READ, 8'($urandom), 1'($urandom), 1'($urandom),
                     1'($urandom));
    endtask

    task automatic send_flag(input urrb_pkg::kind_t kind, input logic fv);
        send_request(kind, 8'($urandom), 1'($urandom), 1'($urandom), fv);
    endtask

    task automatic drain_responses();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_watermark(input logic [7:0] value);
        drain_responses();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        watermark = value;
    endtask

    task automatic test_empty_and_flags();
        send_read();
        send_flag(urrb_pkg::KIND_NEAR_FLAG, 1'b0);
        send_flag(urrb_pkg::KIND_NEAR_FLAG, 1'b1);
        send_flag(urrb_pkg::KIND_OVF_FLAG, 1'b1);
        send_read();
        send_flag(urrb_pkg::KIND_OVF_FLAG, 1'b0);
    endtask

    task automatic test_byte_extremes();
        send_arrival(8'h00, 1'b0, 1'b0);
        send_read();
        send_arrival(8'hff, 1'b1, 1'b1);
        send_read();
        send_arrival(8'ha5, 1'b1, 1'b0);
        send_arrival(8'h5a, 1'b0, 1'b1);
        send_read();
        send_read();
        send_read();
    endtask

    task automatic test_watermark_extremes();
        write_watermark(8'd255);
        send_random_arrival();
        send_random_arrival();
        send_read();
        send_read();
        write_watermark(8'd128);
        send_random_arrival();
        send_read();
    endtask

    // fill to the last slot behind a stalled receiver, drop arrivals, then drain
    task automatic test_ring_full();
        write_watermark(8'd1);
        hold_request = 1'b1;
        repeat (urrb_pkg::BUFFER_DEPTH + 1) send_random_arrival();
        send_read();
        send_read();
        write_watermark(8'd0);
        send_flag(urrb_pkg::KIND_NEAR_FLAG, 1'b1);
        repeat (3) send_random_arrival();
        send_read();
        send_flag(urrb_pkg::KIND_OVF_FLAG, 1'b0);
        repeat (urrb_pkg::BUFFER_DEPTH - 1) send_read();
    endtask

    task automatic test_random_traffic();
        int read_pct;
        int roll;
        logic [7:0] wm_value;
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase % 4)
                0: wm_value = 8'($urandom);
                1: wm_value = 8'd1;
                2: wm_value = 8'd255;
                default: wm_value = 8'd128;
            endcase
            write_watermark(wm_value);
            steady_mode = (phase % 3 == 2);
            read_pct = (phase % 2 == 1) ? $urandom_range(50, 75) : $urandom_range(15, 45);
            repeat (10)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    send_flag(urrb_pkg::KIND_NEAR_FLAG, 1'($urandom));
                else if (roll < 6)
                    send_flag(urrb_pkg::KIND_OVF_FLAG, 1'($urandom));
                else if (roll < 6 + read_pct)
                    send_read();
                else
                    send_random_arrival();
            end
        end
        steady_mode = 1'b0;
    endtask

    initial
    begin : test_sequence
        wr_pos = 0;
        rd_pos = 0;
        err_latch = '0;
        near_empty_model = 1'b1;
        dropped_model = 1'b0;
        watermark = urrb_pkg::WATERMARK_RESET;
        item_ch.valid <= 1'b0;
        item_ch.kind <= urrb_pkg::KIND_BYTE;
        item_ch.rx_byte <= '0;
        item_ch.frame_error_in <= 1'b0;
        item_ch.overrun_error_in <= 1'b0;
        item_ch.flag_value <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        rst_n <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_and_flags();
        test_byte_extremes();
        test_watermark_extremes();
        test_ring_full();
        test_random_traffic();
        drain_responses();
        if (error_count == 0)
            $display("uart_receive_ring_buffer verification clean");
        else
            $display("uart_receive_ring_buffer verification failed");
        $finish;
    end

endmodule

[files.f]
design/urrb_pkg.sv
design/urrb_if.sv
design/uart_receive_ring_buffer.sv
dv/tb_uart_receive_ring_buffer.sv
